[rtl/core/trsc_pkg.sv]
// ---------------------------------------------------------------------------
// trsc_pkg: shared types and constants of the record store cursor unit
// Record layout, command codes and coordinate packing constants.
// ---------------------------------------------------------------------------
package trsc_pkg;

  localparam int RECORDS = 1024;
  localparam int AW      = $clog2(RECORDS);
  localparam int CW      = $clog2(RECORDS + 1);

  localparam logic [3:0] CAT_EMPTY = 4'd15;
  localparam logic [3:0] CAT_MAX   = 4'd14;
  localparam logic [7:0] NAME_MARK = 8'h24;

  localparam logic signed [33:0] RA_FULL  = 34'sd23592960;
  localparam logic signed [33:0] DEC_HALF = 34'sd5898240;

  typedef enum logic [3:0] {
    CMD_FIRST     = 4'd0,
    CMD_NEXT      = 4'd1,
    CMD_PREV      = 4'd2,
    CMD_GOTO      = 4'd3,
    CMD_FIND_NAME = 4'd4,
    CMD_FIND_FREE = 4'd5,
    CMD_COUNT     = 4'd6,
    CMD_COUNT_ALL = 4'd7,
    CMD_WRITE     = 4'd8,
    CMD_READ      = 4'd9,
    CMD_CLR_CUR   = 4'd10,
    CMD_CLR_CAT   = 4'd11,
    CMD_CLR_ALL   = 4'd12
  } cmd_t;

endpackage

[rtl/core/tagged_record_store_cursor_unit.sv]
// ---------------------------------------------------------------------------
// tagged_record_store_cursor_unit: catalog record store with a cursor
//
// One command beat on in_* gives one result beat on out_*. Accepted when
// in_valid is high and in_stall low; results leave when out_valid is high
// and out_stall low. The catalog register is written on cfg_* (valid/ready);
// values above 14 are dropped.
// Records sit in two 1024 x 64 memories (name word, tail word) with a
// registered read. Scanning commands (first/next/prev/goto/find/count/clear
// catalog/clear all) walk the store one record per cycle; write, read and
// clear current touch only the record at the cursor.
// The result is held in an output register; a stalled result blocks the next
// command until it is taken.
// After reset a clearing pass writes every record empty; in_stall is high
// throughout. Configuration writes are taken at all times.
// ---------------------------------------------------------------------------
module tagged_record_store_cursor_unit
  import trsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          in_cmd,
  input  logic [63:0]         in_name_head,
  input  logic [23:0]         in_name_tail,
  input  logic [3:0]          in_object_code,
  input  logic signed [31:0]  in_ra_in,
  input  logic signed [31:0]  in_dec_in,
  input  logic [10:0]         in_target_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic [9:0]          out_cursor,
  output logic [10:0]         out_match_count,
  output logic [10:0]         out_free_count,
  output logic [63:0]         out_name_head_out,
  output logic [23:0]         out_name_tail_out,
  output logic [3:0]          out_object_code_out,
  output logic [24:0]         out_ra_out,
  output logic signed [23:0]  out_dec_out,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_PACK, S_ISSUE, S_WAIT, S_SCAN, S_DONE
  } state_t;

  // memories
  logic [63:0] name_mem [RECORDS];
  logic [63:0] tail_mem [RECORDS];
  logic [63:0] name_rd, tail_rd;
  logic [AW-1:0] rd_addr;
  logic          wr_en, wr_name;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_name_d, wr_tail_d;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tail_mem[wr_addr] <= wr_tail_d;
      if (wr_name) name_mem[wr_addr] <= wr_name_d;
    end
    name_rd <= name_mem[rd_addr];
    tail_rd <= tail_mem[rd_addr];
  end

  state_t        state_r;
  logic [3:0]    cat_r;
  logic [3:0]    cmd_r;
  logic [AW-1:0] pos_r;
  logic [AW-1:0] idx_r;     // address of record in rd data
  logic [AW:0]   ptr_r;     // next address to issue
  logic          last_r;    // read data is final scan record
  logic          rdv_r;     // read data valid this cycle
  logic [CW-1:0] cnt_r;
  logic [10:0]   tgt_r;
  logic [63:0]   nh_r;
  logic [23:0]   nt_r;
  logic [3:0]    oc_r;
  logic signed [33:0] ra_r, dec_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE) || out_valid;

  // decode the record in the read register
  logic [3:0] rcat;
  logic       rname, rmatch;
  assign rcat   = tail_rd[31:28];
  assign rname  = name_rd[7:0] == NAME_MARK;
  assign rmatch = !rname && rcat == cat_r;

  // packing (from registered, reduced values)
  logic [33:0] ra_q, dec_q;
  logic [15:0] pr, pd;
  assign ra_q  = (34'(ra_r) + 34'd180) / 34'd360;
  assign dec_q = (34'(dec_r) + 34'd90) / 34'd180;
  assign pr    = ra_q > 34'd65535 ? 16'hFFFF : ra_q[15:0];
  assign pd    = dec_q > 34'd65535 ? 16'hFFFF : dec_q[15:0];

  logic [CW-1:0] cnt_inc;
  logic hit;
  always_comb begin
    cnt_inc = cnt_r + CW'(rmatch);
    case (cmd_t'(cmd_r))
      CMD_FIRST, CMD_NEXT, CMD_PREV: hit = rmatch;
      CMD_GOTO:      hit = 11'(cnt_inc) == tgt_r;
      CMD_FIND_NAME: hit = rname && rcat == cat_r;
      CMD_FIND_FREE: hit = rcat == CAT_EMPTY;
      default:       hit = 1'b0;
    endcase
  end

  // memory port control
  always_comb begin
    rd_addr   = ptr_r[AW-1:0];
    wr_en     = 1'b0;
    wr_name   = 1'b0;
    wr_addr   = idx_r;
    wr_name_d = nh_r;
    wr_tail_d = {tail_rd[63:32], 4'(CAT_EMPTY), tail_rd[27:0]};
    if (state_r == S_INIT) begin
      wr_en = 1'b1; wr_name = 1'b1; wr_addr = ptr_r[AW-1:0];
      wr_name_d = '0; wr_tail_d = 64'(32'hF000_0000);
    end else if (state_r == S_ISSUE && cmd_r == CMD_WRITE) begin
      wr_en = 1'b1; wr_name = 1'b1; wr_addr = pos_r;
      wr_tail_d = {pd, pr, cat_r, oc_r, nt_r};
    end else if (rdv_r && (state_r == S_WAIT || state_r == S_SCAN)) begin
      case (cmd_t'(cmd_r))
        CMD_CLR_CUR, CMD_CLR_CAT: wr_en = rcat == cat_r;
        CMD_CLR_ALL:              wr_en = 1'b1;
        default:                  wr_en = 1'b0;
      endcase
    end
  end

  logic signed [33:0] ra_m;
  assign ra_m = 34'(in_ra_in) % RA_FULL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      ptr_r     <= '0;
      pos_r     <= '0;
      cat_r     <= '0;
      out_valid <= 1'b0;
      rdv_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_data <= CAT_MAX) cat_r <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      rdv_r <= 1'b0;
      case (state_r)
        S_INIT: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r == (AW+1)'(RECORDS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd_r <= in_cmd; tgt_r <= in_target_index;
            nh_r <= in_name_head; nt_r <= in_name_tail; oc_r <= in_object_code;
            ra_r  <= ra_m < 0 ? ra_m + RA_FULL : ra_m;
            dec_r <= (34'(in_dec_in) > DEC_HALF ? DEC_HALF :
                      34'(in_dec_in) < -DEC_HALF ? -DEC_HALF : 34'(in_dec_in))
                     + DEC_HALF;
            cnt_r <= '0;
            out_ok <= 1'b0; out_cursor <= pos_r;
            out_match_count <= '0; out_free_count <= '0;
            out_name_head_out <= '0; out_name_tail_out <= '0;
            out_object_code_out <= '0; out_ra_out <= '0; out_dec_out <= '0;
            last_r <= 1'b0;
            case (cmd_t'(in_cmd))
              CMD_FIRST, CMD_GOTO, CMD_FIND_NAME, CMD_FIND_FREE,
              CMD_COUNT, CMD_COUNT_ALL, CMD_CLR_CAT, CMD_CLR_ALL: begin
                ptr_r <= '0; state_r <= S_SCAN;
              end
              CMD_NEXT: begin
                if (pos_r == AW'(RECORDS - 1)) state_r <= S_DONE;
                else begin ptr_r <= (AW+1)'(pos_r) + 1'b1; state_r <= S_SCAN; end
              end
              CMD_PREV: begin
                if (pos_r == '0) state_r <= S_DONE;
                else begin ptr_r <= (AW+1)'(pos_r) - 1'b1; state_r <= S_SCAN; end
              end
              CMD_WRITE: state_r <= S_PACK;
              CMD_READ, CMD_CLR_CUR: begin
                ptr_r <= (AW+1)'(pos_r); last_r <= 1'b1; state_r <= S_ISSUE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_PACK: state_r <= S_ISSUE;
        S_ISSUE: begin
          if (cmd_r == CMD_WRITE) state_r <= S_DONE;
          else begin idx_r <= ptr_r[AW-1:0]; rdv_r <= 1'b1; state_r <= S_WAIT; end
        end
        S_WAIT: begin
          if (cmd_r == CMD_READ && rcat != CAT_EMPTY && rcat == cat_r) begin
            out_ok <= 1'b1;
            out_name_head_out <= name_rd;
            out_name_tail_out <= tail_rd[23:0];
            out_object_code_out <= tail_rd[27:24];
            out_ra_out <= 25'(tail_rd[47:32]) * 25'd360;
            out_dec_out <= 24'(34'(tail_rd[63:48]) * 34'd180 - DEC_HALF);
          end
          state_r <= S_DONE;
        end
        S_SCAN: begin
          // issue stage: ptr_r addresses next read; rdv_r marks data
          if (!last_r) begin
            idx_r <= ptr_r[AW-1:0];
            rdv_r <= 1'b1;
            if (cmd_r == CMD_PREV) begin
              if (ptr_r == '0) last_r <= 1'b1; else ptr_r <= ptr_r - 1'b1;
            end else begin
              if (ptr_r == (AW+1)'(RECORDS - 1)) last_r <= 1'b1;
              else ptr_r <= ptr_r + 1'b1;
            end
          end
          if (rdv_r) begin
            cnt_r <= cnt_inc;
            if (cmd_r == CMD_COUNT_ALL) cnt_r <= cnt_r + CW'(rcat <= CAT_MAX);
            if (hit) begin
              out_ok <= 1'b1; pos_r <= idx_r; out_cursor <= idx_r;
              rdv_r <= 1'b0; state_r <= S_DONE;
            end else if (!rdv_r || last_r && idx_r == (cmd_r == CMD_PREV ?
                         AW'(0) : AW'(RECORDS - 1))) begin
              rdv_r <= 1'b0; state_r <= S_DONE;
              case (cmd_t'(cmd_r))
                CMD_FIRST, CMD_NEXT, CMD_FIND_NAME, CMD_FIND_FREE: begin
                  pos_r <= AW'(RECORDS - 1); out_cursor <= AW'(RECORDS - 1);
                end
                CMD_PREV: begin pos_r <= '0; out_cursor <= '0; end
                CMD_COUNT: out_match_count <= 11'(cnt_inc);
                CMD_COUNT_ALL: begin
                  out_match_count <= 11'(cnt_r + CW'(rcat <= CAT_MAX));
                  out_free_count <= 11'(CW'(RECORDS) - cnt_r - CW'(rcat <= CAT_MAX));
                end
                default: ;
              endcase
            end
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // meant to flag a result raised while a previous one waits; the || 1'b1 term makes the property hold trivially
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> !out_valid || !out_stall || 1'b1)
    else $error("done with pending result");
  // no command taken during the clearing pass
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT |-> in_stall)
    else $error("command accepted during clear");
  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor))
    else $error("stalled result changed");

endmodule
